// ===== hw/rtl/tmwp_pkg.sv =====
package tmwp_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TILE_SIZE  = 2'd0,
      REG_IMAGE_ROWS = 2'd1,
      REG_IMAGE_COLS = 2'd2
   } reg_index_type;

   localparam int TILE_REG_W = 9;
   localparam int ROWS_REG_W = 11;
   localparam int COLS_REG_W = 13;

   localparam int TILE_LIMIT  = 256;
   localparam int TILE_W      = 8;
   localparam int TILE_RESET  = 8;
   localparam int ROWS_RESET  = 1024;
   localparam int COLS_RESET  = 1024;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

endpackage

// ===== hw/rtl/tmwp_if.sv =====
interface tmwp_req_if #(
   parameter int PIX_W = 16
);
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface tmwp_rsp_if #(
   parameter int PIX_W = 16,
   parameter int ROW_W = 10,
   parameter int COL_W = 12
);
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] tile_min;
   logic [ROW_W-1:0] min_row;
   logic [COL_W-1:0] min_col;
   logic             last_tile;

   modport source (output valid, output tile_min, output min_row, output min_col,
                   output last_tile, input ready);
   modport sink   (input valid, input tile_min, input min_row, input min_col,
                   input last_tile, output ready);
endinterface

// ===== hw/rtl/tmwp_rsp_fifo.sv =====
module tmwp_rsp_fifo
   import tmwp_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [WIDTH-1:0]     push_data,
   input  logic                 pop,
   output logic                 out_valid,
   output logic [WIDTH-1:0]     out_data,
   output logic [RSP_CNT_W-1:0] count
);

   logic [WIDTH-1:0]     store_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 do_pop;

   assign out_valid = (cnt_ff != '0);
   assign out_data  = store_ff[rd_ptr_ff];
   assign count     = cnt_ff;
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/tile_min_with_position.sv =====
// Tile minimum with position. Pixels arrive in column-major order, one word per
// cycle, and every pixel is accepted at one per clock for as long as the result
// side keeps up. The running minimum of each tile in the current tile column
// lives in one synchronous memory of MAX_ROWS entries indexed by tile row: a
// pixel reads its entry at acceptance, compares and writes it back the next
// cycle, with a bypass when the previous pixel hit the same entry. The result
// for a tile is pushed into a four-word queue at the edge after the one that
// takes the tile's last pixel, and rsp_valid rises from the queue's count
// register once the word is in. Input stalls while the words in the queue
// plus the one in the compare stage reach four. The memory needs no
// clearing pass, as the first pixel of each tile seeds its entry. A write to any
// of the three registers restarts the scan at the first pixel of a new image.
module tile_min_with_position
   import tmwp_pkg::*;
#(
   parameter int MAX_ROWS   = 1024,
   parameter int MAX_COLS   = 4096,
   parameter int PIXEL_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   tmwp_req_if.sink              req_chan,
   tmwp_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROWS_RST = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;
   localparam int COLS_RST = (COLS_RESET > MAX_COLS) ? MAX_COLS : COLS_RESET;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] value;
      logic [ROW_W-1:0]      row;
      logic [COL_W-1:0]      col;
   } entry_type;

   typedef struct packed {
      logic             seed;
      logic             emit;
      logic             last;
      logic [ROW_W-1:0] slot;
      entry_type        cand;
   } stage_type;

   typedef struct packed {
      entry_type ent;
      logic      last;
   } result_type;

   // configuration, held as clamped value minus one
   logic [TILE_W-1:0] ts_m1_ff, ts_m1_in;
   logic [ROW_W-1:0]  rows_m1_ff, rows_m1_in;
   logic [COL_W-1:0]  cols_m1_ff, cols_m1_in;
   logic              cfg_hit;

   logic [TILE_REG_W-1:0] tile_wdata;
   logic [ROWS_REG_W-1:0] rows_wdata;
   logic [COLS_REG_W-1:0] cols_wdata;

   // scan position
   logic [ROW_W-1:0]  row_count_ff, row_count_in;
   logic [COL_W-1:0]  col_count_ff, col_count_in;
   logic [TILE_W-1:0] rit_ff, rit_in;
   logic [TILE_W-1:0] cit_ff, cit_in;
   logic [ROW_W-1:0]  tri_ff, tri_in;

   logic last_row, last_col, rit_end, cit_end;
   logic fire;

   // compare stage and memory
   entry_type best_mem [MAX_ROWS];
   entry_type mem_rd_ff;
   stage_type s1_ff, s1_in;
   logic      s1_valid_ff;
   logic      wb_valid_ff;
   logic [ROW_W-1:0] wb_slot_ff;
   entry_type wb_ent_ff;
   entry_type old_ent, new_ent;
   logic      take;

   // result queue
   result_type           push_res, head_res;
   logic                 push;
   logic [RSP_CNT_W-1:0] rsp_count;

   assign fire = req_chan.valid && req_chan.ready;

   assign tile_wdata = csr_wdata[TILE_REG_W-1:0];
   assign rows_wdata = csr_wdata[ROWS_REG_W-1:0];
   assign cols_wdata = csr_wdata[COLS_REG_W-1:0];

   always_comb begin
      ts_m1_in   = ts_m1_ff;
      rows_m1_in = rows_m1_ff;
      cols_m1_in = cols_m1_ff;
      cfg_hit    = 1'b0;
      if (csr_we) begin
         case (csr_index)
            REG_TILE_SIZE: begin
               cfg_hit = 1'b1;
               if (tile_wdata == '0) begin
                  ts_m1_in = '0;
               end else if (tile_wdata > TILE_REG_W'(TILE_LIMIT)) begin
                  ts_m1_in = TILE_W'(TILE_LIMIT - 1);
               end else begin
                  ts_m1_in = TILE_W'(tile_wdata - 1'b1);
               end
            end
            REG_IMAGE_ROWS: begin
               cfg_hit = 1'b1;
               if (rows_wdata == '0) begin
                  rows_m1_in = '0;
               end else if (32'(rows_wdata) > 32'(MAX_ROWS)) begin
                  rows_m1_in = ROW_W'(MAX_ROWS - 1);
               end else begin
                  rows_m1_in = ROW_W'(rows_wdata - 1'b1);
               end
            end
            REG_IMAGE_COLS: begin
               cfg_hit = 1'b1;
               if (cols_wdata == '0) begin
                  cols_m1_in = '0;
               end else if (32'(cols_wdata) > 32'(MAX_COLS)) begin
                  cols_m1_in = COL_W'(MAX_COLS - 1);
               end else begin
                  cols_m1_in = COL_W'(cols_wdata - 1'b1);
               end
            end
            default: cfg_hit = 1'b0;
         endcase
      end
   end

   assign last_row = (row_count_ff >= rows_m1_ff);
   assign last_col = (col_count_ff >= cols_m1_ff);
   assign rit_end  = (rit_ff >= ts_m1_ff);
   assign cit_end  = (cit_ff >= ts_m1_ff);

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      rit_in       = rit_ff;
      cit_in       = cit_ff;
      tri_in       = tri_ff;
      if (cfg_hit) begin
         // restart at the first pixel of a new image
         row_count_in = '0;
         col_count_in = '0;
         rit_in       = '0;
         cit_in       = '0;
         tri_in       = '0;
      end else if (fire) begin
         if (last_row) begin
            row_count_in = '0;
            rit_in       = '0;
            tri_in       = '0;
            if (last_col) begin
               col_count_in = '0;
               cit_in       = '0;
            end else begin
               col_count_in = col_count_ff + 1'b1;
               cit_in       = cit_end ? '0 : cit_ff + 1'b1;
            end
         end else begin
            row_count_in = row_count_ff + 1'b1;
            if (rit_end) begin
               rit_in = '0;
               tri_in = tri_ff + 1'b1;
            end else begin
               rit_in = rit_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      s1_in.seed       = (rit_ff == '0) && (cit_ff == '0);
      s1_in.emit       = (rit_end || last_row) && (cit_end || last_col);
      s1_in.last       = last_row && last_col;
      s1_in.slot       = tri_ff;
      s1_in.cand.value = req_chan.pixel;
      s1_in.cand.row   = row_count_ff;
      s1_in.cand.col   = col_count_ff;
   end

   // bypass the entry written at the same edge this word's read happened
   assign old_ent = (wb_valid_ff && (wb_slot_ff == s1_ff.slot)) ? wb_ent_ff : mem_rd_ff;
   assign take    = s1_ff.seed || (s1_ff.cand.value < old_ent.value);
   assign new_ent = take ? s1_ff.cand : old_ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_m1_ff     <= TILE_W'(TILE_RESET - 1);
         rows_m1_ff   <= ROW_W'(ROWS_RST - 1);
         cols_m1_ff   <= COL_W'(COLS_RST - 1);
         row_count_ff <= '0;
         col_count_ff <= '0;
         rit_ff       <= '0;
         cit_ff       <= '0;
         tri_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         wb_valid_ff  <= 1'b0;
      end else begin
         ts_m1_ff     <= ts_m1_in;
         rows_m1_ff   <= rows_m1_in;
         cols_m1_ff   <= cols_m1_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         rit_ff       <= rit_in;
         cit_ff       <= cit_in;
         tri_ff       <= tri_in;
         s1_valid_ff  <= fire;
         wb_valid_ff  <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s1_ff <= s1_in;
      end
      wb_slot_ff <= s1_ff.slot;
      wb_ent_ff  <= new_ent;
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         mem_rd_ff <= best_mem[tri_ff];
      end
      if (s1_valid_ff) begin
         best_mem[s1_ff.slot] <= new_ent;
      end
   end

   assign push          = s1_valid_ff && s1_ff.emit;
   assign push_res.ent  = new_ent;
   assign push_res.last = s1_ff.last;

   tmwp_rsp_fifo #(
      .WIDTH($bits(result_type))
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_res),
      .pop       (rsp_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_data  (head_res),
      .count     (rsp_count)
   );

   assign rsp_chan.tile_min  = head_res.ent.value;
   assign rsp_chan.min_row   = head_res.ent.row;
   assign rsp_chan.min_col   = head_res.ent.col;
   assign rsp_chan.last_tile = head_res.last;

   // room for the word in the compare stage and one more
   assign req_chan.ready = (({1'b0, rsp_count} + {{RSP_CNT_W{1'b0}}, s1_valid_ff})
                            < (RSP_CNT_W + 1)'(RSP_DEPTH));

endmodule

// ===== hw/rtl/tmwp_checker.sv =====
module tmwp_checker #(
   parameter int PIX_W = 16,
   parameter int ROW_W = 10,
   parameter int COL_W = 12
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [PIX_W-1:0] rsp_tile_min,
   input logic [ROW_W-1:0] rsp_min_row,
   input logic [COL_W-1:0] rsp_min_col,
   input logic             rsp_last_tile
);

   logic req_fire;

   assign req_fire = req_valid && req_ready;

   // a reset leaves no word pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // no result appears unless a pixel is taken now or was taken at the last sample
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !req_fire && !$past(req_fire)) |=> !rsp_valid)
      else $error("result appeared without input");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_tile_min) && $stable(rsp_min_row) &&
          $stable(rsp_min_col) && $stable(rsp_last_tile)))
      else $error("stalled result changed");

endmodule

bind tile_min_with_position tmwp_checker #(
   .PIX_W (PIXEL_BITS),
   .ROW_W (ROW_W),
   .COL_W (COL_W)
) u_tmwp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_tile_min  (rsp_chan.tile_min),
   .rsp_min_row   (rsp_chan.min_row),
   .rsp_min_col   (rsp_chan.min_col),
   .rsp_last_tile (rsp_chan.last_tile)
);
